[sv/bra_pkg.sv]
package bra_pkg;

    localparam int MAP_BITS   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = $clog2(MAP_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int POS_W      = 10;
    localparam int LEN_W      = 11;
    localparam int CMP_W      = LEN_W + 1;
    localparam int OFF_W      = BIT_W + 1;

    typedef enum logic {
        OP_FIND   = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // per-word search outcome
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] start;
        logic [LEN_W-1:0] next_begin;
    } scan_res_t;

endpackage

[sv/bra_word_scan.sv]
module bra_word_scan (
    input  logic [bra_pkg::WORD_BITS-1:0] word_i,
    input  logic [bra_pkg::LEN_W-1:0]     base_i,
    input  logic [bra_pkg::LEN_W-1:0]     cur_begin_i,
    input  logic [bra_pkg::LEN_W-1:0]     length_i,
    input  logic [bra_pkg::LEN_W-1:0]     limit_i,
    output bra_pkg::scan_res_t            res_o
);
    import bra_pkg::*;

    // lz[k][i]: offset+1 of the last zero at or below bit i, 0 if none (prefix over levels)
    logic [OFF_W-1:0] lz [0:BIT_W][0:WORD_BITS-1];
    logic [LEN_W-1:0] begin_pos [0:WORD_BITS-1];
    logic [LEN_W-1:0] bit_pos   [0:WORD_BITS-1];
    logic [WORD_BITS-1:0] hit_vec;

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            lz[0][i] = word_i[i] ? '0 : OFF_W'(i + 1);
        end
        for (int k = 0; k < BIT_W; k++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (i >= (1 << k) && lz[k][i] == '0) begin
                    lz[k+1][i] = lz[k][i - (1 << k)];
                end else begin
                    lz[k+1][i] = lz[k][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            bit_pos[i]   = base_i + LEN_W'(i);
            begin_pos[i] = (lz[BIT_W][i] != '0)
                         ? base_i + LEN_W'(lz[BIT_W][i]) : cur_begin_i;
            // run ending here reaches the wanted length and stays below the limit
            hit_vec[i]   = word_i[i] && (bit_pos[i] < limit_i) &&
                           (({1'b0, bit_pos[i]} + CMP_W'(1)) >=
                            ({1'b0, begin_pos[i]} + {1'b0, length_i}));
        end
    end

    always_comb begin
        res_o.hit        = 1'b0;
        res_o.start      = '0;
        res_o.next_begin = begin_pos[WORD_BITS-1];
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                res_o.hit   = 1'b1;
                res_o.start = begin_pos[i][POS_W-1:0];
            end
        end
    end

endmodule

[sv/bitmap_run_allocator.sv]
// channel | direction | handshake        | payload
// s_      | in        | s_valid/s_ready  | s_opcode, s_position, s_run_length, s_fill_value
// m_      | out       | m_valid/m_ready  | m_found, m_run_start
// cfg_    | in        | cfg_wr_en        | cfg_wr_data (bits_in_use)
//
// An item walks the map one stored word per cycle through the two-port RAM:
// accept, scan each word visited (up to 32), then load the result register.
// A find stops at the first word holding a run; zero length items skip the walk.
// Reset is synchronous; per-word valid flags make the map read as all free at once.
// A result waiting on m_ready stalls only the finish step, the next item is accepted.
module bitmap_run_allocator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [bra_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic [bra_pkg::POS_W-1:0] s_position,
    input  logic [bra_pkg::LEN_W-1:0] s_run_length,
    input  logic                      s_fill_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_found,
    output logic [bra_pkg::POS_W-1:0] m_run_start
);
    import bra_pkg::*;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     bits_in_use_reg;
    logic [ADDR_W-1:0]    widx_reg, widx_next;
    logic [LEN_W-1:0]     cur_begin_reg, cur_begin_next;
    op_t                  op_reg, op_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [LEN_W-1:0]     end_reg, end_next;
    logic                 fill_reg, fill_next;
    logic                 res_found_reg, res_found_next;
    logic [POS_W-1:0]     res_start_reg, res_start_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic [POS_W-1:0]     m_run_start_reg, m_run_start_next;

    logic [WORD_BITS-1:0] mem [0:MAP_WORDS-1];
    logic [WORD_BITS-1:0] mem_rdata_reg;
    logic [MAP_WORDS-1:0] map_valid_reg;
    logic                 rd_valid_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rword;
    logic [WORD_BITS-1:0] upd_mask;

    logic [LEN_W-1:0]     limit;
    logic [LEN_W-1:0]     base;
    logic [LEN_W-1:0]     base_next;
    logic [LEN_W-1:0]     s_base;
    logic [CMP_W-1:0]     s_end_raw;
    logic [LEN_W-1:0]     s_end;
    logic                 out_free;
    scan_res_t            scan;

    assign limit     = (bits_in_use_reg > LEN_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : bits_in_use_reg;
    assign base      = LEN_W'({widx_reg, {BIT_W{1'b0}}});
    assign base_next = base + LEN_W'(WORD_BITS);
    assign s_base    = LEN_W'({s_position[POS_W-1:BIT_W], {BIT_W{1'b0}}});
    assign s_end_raw = CMP_W'(s_position) + CMP_W'(s_run_length);
    assign s_end     = (s_end_raw > CMP_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : s_end_raw[LEN_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;
    assign rword     = rd_valid_reg ? mem_rdata_reg : '1;

    bra_word_scan u_scan (
        .word_i      (rword),
        .base_i      (base),
        .cur_begin_i (cur_begin_reg),
        .length_i    (len_reg),
        .limit_i     (limit),
        .res_o       (scan)
    );

    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            upd_mask[i] = ((base + LEN_W'(i)) >= LEN_W'(pos_reg)) &&
                          ((base + LEN_W'(i)) < end_reg);
        end
        wdata = fill_reg ? (rword | upd_mask) : (rword & ~upd_mask);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_run_length == '0) begin
                        state_next = ST_FINISH;
                    end else if (s_opcode == OP_FIND && s_base >= limit) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (op_reg == OP_FIND) begin
                    if (scan.hit || base_next >= limit) begin
                        state_next = ST_FINISH;
                    end
                end else if (base_next >= end_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready          = 1'b0;
        rd_addr          = widx_reg + ADDR_W'(1);
        mem_we           = 1'b0;
        widx_next        = widx_reg;
        cur_begin_next   = cur_begin_reg;
        op_next          = op_reg;
        pos_next         = pos_reg;
        len_next         = len_reg;
        end_next         = end_reg;
        fill_next        = fill_reg;
        res_found_next   = res_found_reg;
        res_start_next   = res_start_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_found_next     = m_found_reg;
        m_run_start_next = m_run_start_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                rd_addr        = s_position[POS_W-1:BIT_W];
                widx_next      = s_position[POS_W-1:BIT_W];
                cur_begin_next = s_base;
                op_next        = op_t'(s_opcode);
                pos_next       = s_position;
                len_next       = s_run_length;
                end_next       = s_end;
                fill_next      = s_fill_value;
                res_found_next = 1'b0;
                res_start_next = '0;
            end
            ST_RUN: begin
                widx_next      = widx_reg + ADDR_W'(1);
                cur_begin_next = scan.next_begin;
                if (op_reg == OP_FIND) begin
                    if (scan.hit) begin
                        res_found_next = 1'b1;
                        res_start_next = scan.start;
                    end
                end else begin
                    mem_we = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_found_next     = res_found_reg;
                    m_run_start_next = res_start_reg;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[widx_reg] <= wdata;
        end
        mem_rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            bits_in_use_reg <= LEN_W'(MAP_BITS);
            map_valid_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            rd_valid_reg <= map_valid_reg[rd_addr];
            if (mem_we) begin
                map_valid_reg[widx_reg] <= 1'b1;
            end
            if (cfg_wr_en) begin
                bits_in_use_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        widx_reg        <= widx_next;
        cur_begin_reg   <= cur_begin_next;
        op_reg          <= op_next;
        pos_reg         <= pos_next;
        len_reg         <= len_next;
        end_reg         <= end_next;
        fill_reg        <= fill_next;
        res_found_reg   <= res_found_next;
        res_start_reg   <= res_start_next;
        m_found_reg     <= m_found_next;
        m_run_start_reg <= m_run_start_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_found     = m_found_reg;
    assign m_run_start = m_run_start_reg;

endmodule

[sv/bra_checker.sv]
module bra_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_found,
    input logic [bra_pkg::POS_W-1:0] m_run_start
);
    import bra_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_run_start))
        else $error("result changed while stalled");

    // start reads zero for a miss or an update
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_run_start == '0)
        else $error("non-zero start without a run found");

    // one item at a time: busy right after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);

[test/bitmap_run_allocator_tb.sv]
module bitmap_run_allocator_tb;
    import bra_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned REPORT_MAX    = 10;

    typedef struct {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             fill;
    } alloc_req_t;

    typedef struct {
        int unsigned      item_no;
        logic             found;
        logic [POS_W-1:0] start;
    } run_result_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic             s_opcode;
    logic [POS_W-1:0] s_position;
    logic [LEN_W-1:0] s_run_length;
    logic             s_fill_value;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_found;
    logic [POS_W-1:0] m_run_start;

    // shadow copy of the block's map and limit register
    logic [MAP_BITS-1:0] free_units        = '1;
    logic [LEN_W-1:0]    bits_in_use_model = 11'd1024;

    run_result_t expected_runs[$];

    int unsigned items_sent    = 0;
    int unsigned finds_sent    = 0;
    int unsigned finds_hit     = 0;
    int unsigned updates_sent  = 0;
    int unsigned limits_set    = 0;
    int unsigned results_seen  = 0;
    int unsigned fail_count    = 0;
    int unsigned burst_left    = 0;

    logic [15:0] ready_pattern = 16'hffff;
    logic [5:0]  ready_phase   = '0;

    bitmap_run_allocator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_position   (s_position),
        .s_run_length (s_run_length),
        .s_fill_value (s_fill_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_run_start  (m_run_start)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // first-fit search over the shadow map; updates write the shadow map
    function automatic run_result_t predict_first_fit(input alloc_req_t req);
        run_result_t res;
        int          stop;
        int          limit;
        int          base;
        int          run_len;
        int          run_begin;
        res.item_no = 0;
        res.found   = 1'b0;
        res.start   = '0;
        if (req.op == OP_UPDATE) begin
            stop = int'(req.pos) + int'(req.len);
            if (stop > MAP_BITS)
                stop = MAP_BITS;
            for (int p = int'(req.pos); p < stop; p++)
                free_units[p] = req.fill;
        end else if (req.len != 0) begin
            limit = (int'(bits_in_use_model) > MAP_BITS) ? MAP_BITS : int'(bits_in_use_model);
            base = int'(req.pos) - int'(req.pos) % WORD_BITS;
            run_len = 0;
            run_begin = 0;
            for (int p = base; p < limit && !res.found; p++) begin
                if (free_units[p]) begin
                    if (run_len == 0)
                        run_begin = p;
                    run_len++;
                    if (run_len >= int'(req.len)) begin
                        res.found = 1'b1;
                        res.start = run_begin[POS_W-1:0];
                    end
                end else begin
                    run_len = 0;
                end
            end
        end
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    // sender: bursts of random length, random gaps between them (sometimes none)
    task automatic send_item(input op_t op, input logic [POS_W-1:0] pos,
                             input logic [LEN_W-1:0] len, input logic fill);
        alloc_req_t  req;
        run_result_t res;
        int unsigned gap;
        req = '{op, pos, len, fill};
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_position   <= pos;
        s_run_length <= len;
        s_fill_value <= fill;
        do @(posedge aclk); while (!s_ready);
        res = predict_first_fit(req);
        res.item_no = items_sent;
        expected_runs.push_back(res);
        items_sent++;
        if (op == OP_FIND) begin
            finds_sent++;
            if (res.found)
                finds_hit++;
        end else begin
            updates_sent++;
        end
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // limit register only changes with the block idle
    task automatic write_bits_in_use(input logic [LEN_W-1:0] value);
        wait_all_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        bits_in_use_model = value;
        limits_set++;
    endtask

    task automatic test_fresh_map();
        send_item(OP_FIND, 10'd0, 11'd1, 1'b0);
        send_item(OP_FIND, 10'd0, 11'd1024, 1'b0);    // run ending at the map's end
        send_item(OP_FIND, 10'd0, 11'd1025, 1'b0);
        send_item(OP_FIND, 10'd1023, 11'd1, 1'b1);    // start rounds down to 992
        send_item(OP_FIND, 10'd37, 11'd0, 1'b1);      // zero length
        send_item(OP_FIND, 10'd1023, 11'd2047, 1'b1);
    endtask

    task automatic test_update_ranges();
        send_item(OP_UPDATE, 10'd0, 11'd1, 1'b0);
        send_item(OP_FIND, 10'd0, 11'd1, 1'b0);
        send_item(OP_UPDATE, 10'd1000, 11'd2047, 1'b0);  // clipped at the map's end
        send_item(OP_FIND, 10'd960, 11'd40, 1'b0);
        send_item(OP_FIND, 10'd960, 11'd41, 1'b0);
        send_item(OP_UPDATE, 10'd5, 11'd0, 1'b0);        // no change
        send_item(OP_FIND, 10'd0, 11'd5, 1'b1);
        send_item(OP_UPDATE, 10'd960, 11'd63, 1'b0);
        send_item(OP_UPDATE, 10'd1023, 11'd1, 1'b1);
        send_item(OP_FIND, 10'd1000, 11'd1, 1'b0);       // only the last bit is free
        send_item(OP_UPDATE, 10'd0, 11'd1024, 1'b1);
        send_item(OP_FIND, 10'd0, 11'd1024, 1'b0);
    endtask

    task automatic test_search_limit();
        write_bits_in_use(11'd2047);                     // clamps to the map size
        send_item(OP_FIND, 10'd0, 11'd1024, 1'b0);
        send_item(OP_FIND, 10'd0, 11'd1025, 1'b0);
        write_bits_in_use(11'd100);
        send_item(OP_FIND, 10'd0, 11'd100, 1'b0);
        send_item(OP_FIND, 10'd0, 11'd101, 1'b0);
        send_item(OP_UPDATE, 10'd600, 11'd10, 1'b0);     // updates ignore the limit
        send_item(OP_FIND, 10'd96, 11'd4, 1'b0);
        send_item(OP_FIND, 10'd128, 11'd1, 1'b0);
        write_bits_in_use(11'd0);
        send_item(OP_FIND, 10'd0, 11'd1, 1'b0);
        write_bits_in_use(11'd1024);
        send_item(OP_FIND, 10'd576, 11'd30, 1'b0);
    endtask

    task automatic run_random_items(input int unsigned count);
        int unsigned      pick;
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             fill;
        for (int unsigned i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            pos  = POS_W'($urandom);
            fill = 1'($urandom);
            if ($urandom_range(0, 3) == 0)
                pos[BIT_W-1:0] = '0;
            if (pick < 45) begin
                op = OP_FIND;
                case ($urandom_range(0, 19))
                    0: len = '0;
                    1, 2: len = LEN_W'($urandom_range(1025, 2047));
                    3, 4, 5: len = LEN_W'($urandom_range(49, 1024));
                    default: len = LEN_W'($urandom_range(1, 48));
                endcase
            end else if (pick < 85) begin
                // short carves fragment the map
                op  = OP_UPDATE;
                len = LEN_W'($urandom_range(1, 64));
            end else if (pick < 95) begin
                // long updates mostly free space again
                op   = OP_UPDATE;
                len  = LEN_W'($urandom_range(65, 1024));
                fill = ($urandom_range(0, 3) != 0);
            end else begin
                op  = op_t'($urandom_range(0, 1));
                len = LEN_W'($urandom);
            end
            send_item(op, pos, len, fill);
        end
    endtask

    task automatic test_random_traffic();
        int unsigned steps[8];
        steps = '{1024, 700, 33, 1, 2047, 1023, 512, 0};
        steps[7] = $urandom_range(2, 1022);
        foreach (steps[k]) begin
            write_bits_in_use(LEN_W'(steps[k]));
            run_random_items(50);
        end
    endtask

    // receiver: rotating stall pattern, reselected whenever the 6-bit phase counter wraps
    always @(posedge aclk) begin
        ready_phase <= ready_phase + 6'd1;
        if (ready_phase == '0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern <= '1;
                1: ready_pattern <= 16'($urandom);
                2: ready_pattern <= 16'($urandom) | 16'($urandom);
                default: ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
            endcase
        end else begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        m_ready <= ready_pattern[0];
    end

    always @(posedge aclk) begin
        run_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_runs.size() == 0) begin
                note_failure($sformatf("unexpected result transfer: found=%0b start=%0d",
                                       m_found, m_run_start));
            end else begin
                want = expected_runs.pop_front();
                results_seen++;
                if (m_found !== want.found || m_run_start !== want.start)
                    note_failure($sformatf(
                        "item %0d: expected found=%0b start=%0d, got found=%0b start=%0d",
                        want.item_no, want.found, want.start, m_found, m_run_start));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, expected_runs.size());
        $display("bitmap_run_allocator_tb NOT OK");
        $finish;
    end

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_opcode     <= OP_FIND;
        s_position   <= '0;
        s_run_length <= '0;
        s_fill_value <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_fresh_map();
        test_update_ranges();
        test_search_limit();
        test_random_traffic();
        wait_all_results();

        $display("%0d items: %0d finds (%0d located a run), %0d updates, %0d results checked",
                 items_sent, finds_sent, finds_hit, updates_sent, results_seen);
        $display("%0d limit register writes, %0d failures", limits_set, fail_count);
        if (fail_count == 0 && expected_runs.size() == 0) begin
            $display("bitmap_run_allocator_tb OK");
        end else begin
            $display("bitmap_run_allocator_tb NOT OK");
        end
        $finish;
    end

endmodule
